// ===== sv/stab_pkg.sv =====
// Package for the soft timer, alarm and event bank.
// Holds slot counts, widths, command and event codes, and the
// controller/datapath handshake structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stab_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int ALARM_SLOTS = 8;
  localparam int TOPIC_SLOTS = 8;
  localparam int COUNT_WIDTH = 32;

  localparam int TIMER_AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int ALARM_AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int TOPIC_AW = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;

  // The tick walk visits timer slot i and alarm slot i in the same step.
  localparam int WALK_SLOTS = (TIMER_SLOTS > ALARM_SLOTS) ? TIMER_SLOTS : ALARM_SLOTS;
  localparam int WALK_AW    = (WALK_SLOTS > 1) ? $clog2(WALK_SLOTS) : 1;

  localparam int CMD_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int FIELD_W = 32;
  localparam int KIND_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 4'd0,
    CMD_TIMER_ADD    = 4'd1,
    CMD_TIMER_REMOVE = 4'd2,
    CMD_ALARM_ADD    = 4'd3,
    CMD_ALARM_REMOVE = 4'd4,
    CMD_ALARM_COUNT  = 4'd5,
    CMD_PUBLISH      = 4'd6,
    CMD_SERVICE      = 4'd7,
    CMD_TOPIC_ADD    = 4'd8,
    CMD_TOPIC_REMOVE = 4'd9
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_TOPIC = 2'd1,
    KIND_ALARM = 2'd2
  } kind_t;

  typedef struct packed {
    logic               take;
    logic               tick_inc;
    logic               apply;
    logic               rd;
    logic               wr;
    logic [WALK_AW-1:0] idx;
    logic               emit_ack;
    logic               emit_topic;
    logic               emit_alarm;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic sched_en;
    logic out_free;
    logic topic_any;
    logic topic_last;
    logic alarm_any;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/stab_req_if.sv =====
// Request channel interface: one command transaction per valid/ready handshake.
// Depends on nothing but its own field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stab_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [2:0]  slot;
  logic [31:0] count_value;
  logic [31:0] reload_value;
  logic [2:0]  topic_id;

  modport source (output valid, cmd, slot, count_value, reload_value, topic_id,
                  input ready);
  modport sink (input valid, cmd, slot, count_value, reload_value, topic_id,
                output ready);
endinterface

`default_nettype wire

// ===== sv/stab_evt_if.sv =====
// Event channel interface: one result transaction per valid/ready handshake.
// Depends on nothing but its own field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stab_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  event_id;
  logic [31:0] tick_now;
  logic        last;

  modport source (output valid, event_kind, event_id, tick_now, last, input ready);
  modport sink (input valid, event_kind, event_id, tick_now, last, output ready);
endinterface

`default_nettype wire

// ===== sv/stab_ctrl.sv =====
// Controller state machine for the timer bank: sequences decode, the tick
// walk over the slots, service dispatch and acknowledges. Uses stab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stab_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  stab_pkg::dp_stat_t  stat,
  output stab_pkg::ctrl_cmd_t ctl
);
  import stab_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_WR,
    S_SERVICE,
    S_ACK
  } state_t;

  state_t             state;
  logic [WALK_AW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          idx <= '0;
          if (stat.cmd == CMD_TICK) begin
            state <= stat.sched_en ? S_TICK_RD : S_ACK;
          end else if (stat.cmd == CMD_SERVICE) begin
            state <= S_SERVICE;
          end else begin
            state <= S_ACK;
          end
        end
        S_TICK_RD: state <= S_TICK_WR;
        S_TICK_WR: begin
          if (idx == WALK_AW'(WALK_SLOTS - 1)) begin
            state <= S_ACK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TICK_RD;
          end
        end
        S_SERVICE: begin
          // Stay while the output is busy or further events remain to be sent.
          if (stat.out_free && (!stat.topic_any || stat.topic_last)) state <= S_IDLE;
        end
        S_ACK: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    req_ready      = (state == S_IDLE);
    ctl.take       = (state == S_IDLE) && req_valid;
    ctl.tick_inc   = (state == S_DECODE) && (stat.cmd == CMD_TICK);
    ctl.apply      = (state == S_DECODE) && (stat.cmd != CMD_TICK)
                     && (stat.cmd != CMD_SERVICE);
    ctl.rd         = (state == S_TICK_RD);
    ctl.wr         = (state == S_TICK_WR);
    ctl.idx        = idx;
    ctl.emit_topic = (state == S_SERVICE) && stat.out_free && stat.topic_any;
    ctl.emit_alarm = (state == S_SERVICE) && stat.out_free && !stat.topic_any
                     && stat.alarm_any;
    ctl.emit_ack   = ((state == S_ACK) && stat.out_free)
                     || ((state == S_SERVICE) && stat.out_free && !stat.topic_any
                         && !stat.alarm_any);
  end

endmodule

`default_nettype wire

// ===== sv/stab_datapath.sv =====
// Datapath of the timer bank: command registers, slot state, count memories,
// the tick decrement unit and the output register. Uses stab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stab_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_write_data,
  input  logic [3:0]          cmd_in,
  input  logic [2:0]          slot_in,
  input  logic [31:0]         count_in,
  input  logic [31:0]         reload_in,
  input  logic [2:0]          topic_in,
  input  stab_pkg::ctrl_cmd_t ctl,
  output stab_pkg::dp_stat_t  stat,
  input  logic                evt_ready,
  output logic                evt_valid,
  output logic [1:0]          event_kind,
  output logic [2:0]          event_id,
  output logic [31:0]         tick_now,
  output logic                last
);
  import stab_pkg::*;

  // Latched command.
  cmd_t                   cmd_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [COUNT_WIDTH-1:0] rel_q;
  logic [SLOT_W-1:0]      topic_q;

  logic                   sched_en;
  logic [FIELD_W-1:0]     tick_counter;
  logic [TIMER_SLOTS-1:0] timer_active;
  logic [ALARM_SLOTS-1:0] alarm_active;
  logic [ALARM_SLOTS-1:0] alarm_fired;
  logic [ALARM_SLOTS-1:0] acnt_valid;
  logic [TOPIC_SLOTS-1:0] topic_reg;
  logic [TOPIC_SLOTS-1:0] topic_pend;

  logic [COUNT_WIDTH-1:0] timer_count  [TIMER_SLOTS];
  logic [COUNT_WIDTH-1:0] timer_reload [TIMER_SLOTS];
  logic [SLOT_W-1:0]      timer_target [TIMER_SLOTS];
  logic [COUNT_WIDTH-1:0] alarm_count  [ALARM_SLOTS];

  // Registered read data of the tick walk.
  logic [COUNT_WIDTH-1:0] tc_q;
  logic [COUNT_WIDTH-1:0] tr_q;
  logic [SLOT_W-1:0]      tt_q;
  logic [COUNT_WIDTH-1:0] ac_raw;
  logic                   ac_vld_q;

  logic [TIMER_AW-1:0]    ts;
  logic [ALARM_AW-1:0]    as;
  logic [TOPIC_AW-1:0]    tp;
  logic                   ts_ok;
  logic                   as_ok;
  logic                   tp_ok;
  logic [TIMER_AW-1:0]    wt;
  logic [ALARM_AW-1:0]    wa;
  logic                   wt_ok;
  logic                   wa_ok;

  logic [COUNT_WIDTH-1:0] ac_q;
  logic                   t_hit;
  logic [COUNT_WIDTH-1:0] t_new;
  logic [COUNT_WIDTH-1:0] a_new;
  logic                   tt_ok;

  logic [TOPIC_SLOTS-1:0] topic_ready;
  logic [TOPIC_SLOTS-1:0] topic_one;
  logic [TOPIC_AW-1:0]    first_topic;
  logic [ALARM_SLOTS-1:0] alarm_ready;
  logic [ALARM_AW-1:0]    first_alarm;

  always_comb begin
    ts    = TIMER_AW'(slot_q);
    as    = ALARM_AW'(slot_q);
    tp    = TOPIC_AW'(topic_q);
    ts_ok = 32'(slot_q) < TIMER_SLOTS;
    as_ok = 32'(slot_q) < ALARM_SLOTS;
    tp_ok = 32'(topic_q) < TOPIC_SLOTS;
    wt    = TIMER_AW'(ctl.idx);
    wa    = ALARM_AW'(ctl.idx);
    wt_ok = 32'(ctl.idx) < TIMER_SLOTS;
    wa_ok = 32'(ctl.idx) < ALARM_SLOTS;
  end

  // A count reaching zero on this tick means it read as one.
  always_comb begin
    ac_q  = ac_vld_q ? ac_raw : '0;
    t_hit = (tc_q == COUNT_WIDTH'(1));
    t_new = t_hit ? tr_q : tc_q - COUNT_WIDTH'(1);
    a_new = ac_q - COUNT_WIDTH'(1);
    tt_ok = 32'(tt_q) < TOPIC_SLOTS;
  end

  // Lowest pending registered topic and lowest fired alarm.
  always_comb begin
    topic_ready = topic_reg & topic_pend;
    alarm_ready = alarm_active & alarm_fired;
    first_topic = '0;
    first_alarm = '0;
    for (int i = TOPIC_SLOTS - 1; i >= 0; i--) begin
      if (topic_ready[i]) first_topic = TOPIC_AW'(i);
    end
    for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
      if (alarm_ready[i]) first_alarm = ALARM_AW'(i);
    end
    topic_one = '0;
    topic_one[first_topic] = 1'b1;
  end

  always_comb begin
    stat.cmd        = cmd_q;
    stat.sched_en   = sched_en;
    stat.out_free   = !evt_valid || evt_ready;
    stat.topic_any  = |topic_ready;
    stat.alarm_any  = |alarm_ready;
    stat.topic_last = ((topic_ready & ~topic_one) == '0) && !(|alarm_ready);
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q   <= cmd_t'(cmd_in);
      slot_q  <= slot_in;
      cnt_q   <= COUNT_WIDTH'(count_in);
      rel_q   <= COUNT_WIDTH'(reload_in);
      topic_q <= topic_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_en     <= 1'b0;
      tick_counter <= '0;
      timer_active <= '0;
      alarm_active <= '0;
      alarm_fired  <= '0;
      acnt_valid   <= '0;
      topic_reg    <= '0;
      topic_pend   <= '0;
    end else begin
      if (cfg_write_en) sched_en <= cfg_write_data;
      if (ctl.tick_inc) tick_counter <= tick_counter + 1'b1;
      if (ctl.apply) begin
        unique case (cmd_q)
          CMD_TIMER_ADD: begin
            if (ts_ok && !timer_active[ts]) timer_active[ts] <= 1'b1;
          end
          CMD_TIMER_REMOVE: begin
            if (ts_ok) timer_active[ts] <= 1'b0;
          end
          CMD_ALARM_ADD: begin
            if (as_ok) alarm_active[as] <= 1'b1;
          end
          CMD_ALARM_REMOVE: begin
            if (as_ok) begin
              alarm_active[as] <= 1'b0;
              alarm_fired[as]  <= 1'b0;
            end
          end
          CMD_ALARM_COUNT: begin
            if (as_ok) acnt_valid[as] <= 1'b1;
          end
          CMD_PUBLISH: begin
            if (tp_ok) topic_pend[tp] <= 1'b1;
          end
          CMD_TOPIC_ADD: begin
            if (tp_ok) topic_reg[tp] <= 1'b1;
          end
          CMD_TOPIC_REMOVE: begin
            if (tp_ok) topic_reg[tp] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (ctl.wr) begin
        if (wa_ok && alarm_active[wa]) begin
          acnt_valid[wa] <= 1'b1;
          if (ac_q == COUNT_WIDTH'(1)) alarm_fired[wa] <= 1'b1;
        end
        if (wt_ok && timer_active[wt] && t_hit && tt_ok) begin
          topic_pend[TOPIC_AW'(tt_q)] <= 1'b1;
        end
      end
      if (ctl.emit_topic) topic_pend[first_topic] <= 1'b0;
      if (ctl.emit_alarm) begin
        alarm_active[first_alarm] <= 1'b0;
        alarm_fired[first_alarm]  <= 1'b0;
      end
    end
  end

  // Timer memories: written by a timer add or by the tick walk.
  always_ff @(posedge clk) begin
    if (ctl.apply && (cmd_q == CMD_TIMER_ADD) && ts_ok && !timer_active[ts]) begin
      timer_count[ts]  <= cnt_q;
      timer_reload[ts] <= rel_q;
      timer_target[ts] <= topic_q;
    end else if (ctl.wr && wt_ok && timer_active[wt]) begin
      timer_count[wt] <= t_new;
    end
    if (ctl.rd) begin
      tc_q <= timer_count[wt];
      tr_q <= timer_reload[wt];
      tt_q <= timer_target[wt];
    end
  end

  // Alarm count memory; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (ctl.apply && (cmd_q == CMD_ALARM_COUNT) && as_ok) begin
      alarm_count[as] <= cnt_q;
    end else if (ctl.wr && wa_ok && alarm_active[wa]) begin
      alarm_count[wa] <= a_new;
    end
    if (ctl.rd) begin
      ac_raw   <= alarm_count[wa];
      ac_vld_q <= acnt_valid[wa];
    end
  end

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (ctl.emit_ack || ctl.emit_topic || ctl.emit_alarm) begin
      evt_valid <= 1'b1;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_topic) begin
      event_kind <= KIND_TOPIC;
      event_id   <= SLOT_W'(first_topic);
      tick_now   <= tick_counter;
      last       <= stat.topic_last;
    end else if (ctl.emit_alarm) begin
      event_kind <= KIND_ALARM;
      event_id   <= SLOT_W'(first_alarm);
      tick_now   <= tick_counter;
      last       <= 1'b1;
    end else if (ctl.emit_ack) begin
      event_kind <= KIND_ACK;
      event_id   <= '0;
      tick_now   <= tick_counter;
      last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/soft_timer_alarm_event_bank_top.sv =====
// Top level of the soft timer, alarm and event bank.
// Depends on stab_pkg, stab_req_if, stab_evt_if, stab_ctrl and stab_datapath.
//
//   Channel   Direction  Handshake            Carries
//   req       in         valid/ready          cmd, slot, count_value, reload_value, topic_id
//   evt       out        valid/ready          event_kind, event_id, tick_now, last
//   cfg       in         cfg_write_en only    schedule_enable (cfg_write_data)
//
// A command is decoded and then acknowledged; a tick with scheduling enabled walks all
// WALK_SLOTS slot positions, reading and writing back one timer and one alarm slot at a
// time through the count memories, before its acknowledge. A service sends up to nine
// results (ready topics, then one fired alarm), stalling while the consumer is not ready.
// Reset is synchronous; no clearing pass: alarm counts carry valid bits.
// The output register lets the next command be accepted while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module soft_timer_alarm_event_bank_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic             cfg_write_data,
  stab_req_if.sink         req,
  stab_evt_if.source       evt
);
  import stab_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  stab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  stab_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd_in         (req.cmd),
    .slot_in        (req.slot),
    .count_in       (req.count_value),
    .reload_in      (req.reload_value),
    .topic_in       (req.topic_id),
    .ctl            (ctl),
    .stat           (stat),
    .evt_ready      (evt.ready),
    .evt_valid      (evt.valid),
    .event_kind     (evt.event_kind),
    .event_id       (evt.event_id),
    .tick_now       (evt.tick_now),
    .last           (evt.last)
  );

endmodule

`default_nettype wire

// ===== sv/stab_checker.sv =====
// Port-level checks for the timer bank top level, attached by bind.
// Depends on stab_pkg and soft_timer_alarm_event_bank_top.
`timescale 1ns / 1ps
`default_nettype none

module stab_checker (
  input logic        clk,
  input logic        rst,
  input logic        evt_valid,
  input logic        evt_ready,
  input logic [1:0]  evt_kind,
  input logic [2:0]  evt_id,
  input logic [31:0] evt_tick,
  input logic        evt_last
);
  import stab_pkg::*;

  // A stalled result transaction holds its contents.
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_kind) && $stable(evt_id)
      && $stable(evt_tick) && $stable(evt_last))
    else $error("result changed while stalled");

  // An acknowledge is always the only result and names slot zero.
  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt_kind == KIND_ACK) |-> (evt_id == 3'd0) && evt_last)
    else $error("acknowledge malformed");

  // A fired alarm is always the final result of a service.
  a_alarm_last: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt_kind == KIND_ALARM) |-> evt_last)
    else $error("alarm event not last");

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("result valid after reset");

endmodule

bind soft_timer_alarm_event_bank_top stab_checker u_stab_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .evt_kind  (evt.event_kind),
  .evt_id    (evt.event_id),
  .evt_tick  (evt.tick_now),
  .evt_last  (evt.last)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the soft timer, alarm and event bank.
// Depends on stab_pkg, stab_req_if, stab_evt_if and soft_timer_alarm_event_bank_top.
// An in-bench model of the bank predicts every event, and each event is compared in order.
`timescale 1ns / 1ps

module tb;
  import stab_pkg::*;

  typedef struct {
    kind_t              kind;
    logic [SLOT_W-1:0]  id;
    logic [FIELD_W-1:0] tick;
    logic               last;
  } bank_event_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;

  stab_req_if req_ch ();
  stab_evt_if evt_ch ();

  soft_timer_alarm_event_bank_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req           (req_ch),
    .evt           (evt_ch)
  );

  // Mirror of the bank state.
  logic [FIELD_W-1:0]     tick_count;
  logic                   tmr_active [TIMER_SLOTS];
  logic [COUNT_WIDTH-1:0] tmr_count  [TIMER_SLOTS];
  logic [COUNT_WIDTH-1:0] tmr_reload [TIMER_SLOTS];
  logic [TOPIC_AW-1:0]    tmr_target [TIMER_SLOTS];
  logic                   alm_active [ALARM_SLOTS];
  logic [COUNT_WIDTH-1:0] alm_count  [ALARM_SLOTS];
  logic                   alm_fired  [ALARM_SLOTS];
  logic                   topic_reg  [TOPIC_SLOTS];
  logic                   topic_pend [TOPIC_SLOTS];
  logic                   sched_on;

  bank_event_t pending_events[$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int command_count;
  int result_count;
  int topic_event_count;
  int alarm_event_count;
  int schedule_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("%0d ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                 input logic [FIELD_W-1:0] cnt, input logic [FIELD_W-1:0] rel,
                                 input logic [TOPIC_AW-1:0] topic);
    bank_event_t batch[$];
    bank_event_t ev;
    bit          alarm_taken;
    alarm_taken = 1'b0;
    case (cmd)
      CMD_TICK: begin
        tick_count = tick_count + 1'b1;
        if (sched_on) begin
          for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (alm_active[i]) begin
              alm_count[i] = alm_count[i] - 1'b1;
              if (alm_count[i] == '0) alm_fired[i] = 1'b1;
            end
          end
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (tmr_active[i]) begin
              tmr_count[i] = tmr_count[i] - 1'b1;
              if (tmr_count[i] == '0) begin
                tmr_count[i] = tmr_reload[i];
                topic_pend[tmr_target[i]] = 1'b1;
              end
            end
          end
        end
      end
      CMD_TIMER_ADD: begin
        if (!tmr_active[slot]) begin
          tmr_active[slot] = 1'b1;
          tmr_count[slot]  = cnt;
          tmr_reload[slot] = rel;
          tmr_target[slot] = topic;
        end
      end
      CMD_TIMER_REMOVE: tmr_active[slot] = 1'b0;
      CMD_ALARM_ADD:    alm_active[slot] = 1'b1;
      CMD_ALARM_REMOVE: begin
        alm_active[slot] = 1'b0;
        alm_fired[slot]  = 1'b0;
      end
      CMD_ALARM_COUNT:  alm_count[slot] = cnt;
      CMD_PUBLISH:      topic_pend[topic] = 1'b1;
      CMD_TOPIC_ADD:    topic_reg[topic] = 1'b1;
      CMD_TOPIC_REMOVE: topic_reg[topic] = 1'b0;
      CMD_SERVICE: begin
        for (int i = 0; i < TOPIC_SLOTS; i++) begin
          if (topic_reg[i] && topic_pend[i]) begin
            topic_pend[i] = 1'b0;
            ev.kind = KIND_TOPIC;
            ev.id   = SLOT_W'(i);
            batch.push_back(ev);
            topic_event_count++;
          end
        end
        // Only the lowest fired alarm is reported per service.
        for (int i = 0; i < ALARM_SLOTS; i++) begin
          if (!alarm_taken && alm_active[i] && alm_fired[i]) begin
            alm_active[i] = 1'b0;
            alm_fired[i]  = 1'b0;
            alarm_taken   = 1'b1;
            ev.kind = KIND_ALARM;
            ev.id   = SLOT_W'(i);
            batch.push_back(ev);
            alarm_event_count++;
          end
        end
      end
      default: ;
    endcase
    if (batch.size() == 0) begin
      ev.kind = KIND_ACK;
      ev.id   = '0;
      batch.push_back(ev);
    end
    foreach (batch[i]) begin
      batch[i].tick = tick_count;
      batch[i].last = (i == batch.size() - 1);
      pending_events.push_back(batch[i]);
    end
  endtask

  // Called at a rising edge; returns at the edge where the transaction was accepted.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                              input logic [FIELD_W-1:0] cnt, input logic [FIELD_W-1:0] rel,
                              input logic [TOPIC_AW-1:0] topic);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.slot         <= slot;
    req_ch.count_value  <= cnt;
    req_ch.reload_value <= rel;
    req_ch.topic_id     <= topic;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_command(cmd, slot, cnt, rel, topic);
    command_count++;
  endtask

  task automatic drain_events();
    req_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic set_schedule(input logic on);
    drain_events();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= on;
    sched_on = on;
    schedule_writes++;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic send_random_command();
    int                  r;
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   slot;
    logic [TOPIC_AW-1:0] topic;
    logic [FIELD_W-1:0]  cnt;
    logic [FIELD_W-1:0]  rel;
    r     = $urandom_range(0, 99);
    slot  = SLOT_W'($urandom);
    topic = TOPIC_AW'($urandom);
    cnt   = pick_count();
    rel   = pick_count();
    if (r < 30)      cmd = CMD_TICK;
    else if (r < 42) cmd = CMD_SERVICE;
    else if (r < 50) cmd = CMD_PUBLISH;
    else if (r < 58) cmd = CMD_TOPIC_ADD;
    else if (r < 62) cmd = CMD_TOPIC_REMOVE;
    else if (r < 70) cmd = CMD_TIMER_ADD;
    else if (r < 74) cmd = CMD_TIMER_REMOVE;
    else if (r < 84) cmd = CMD_ALARM_COUNT;
    else if (r < 90) cmd = CMD_ALARM_ADD;
    else if (r < 95) cmd = CMD_ALARM_REMOVE;
    else             cmd = CMD_W'($urandom_range(15, CMD_TOPIC_REMOVE + 1));
    send_command(cmd, slot, cnt, rel, topic);
  endtask

  // Empty bank, unused codes, and topic registration versus pending flags.
  task automatic test_idle_bank();
    send_command(CMD_SERVICE, 0, 0, 0, 0);
    send_command(4'd15, 7, '1, '1, 7);
    send_command(CMD_TICK, 0, 0, 0, 0);
    send_command(CMD_PUBLISH, 0, 0, 0, 7);
    send_command(CMD_SERVICE, 0, 0, 0, 0);
    send_command(CMD_TOPIC_ADD, 0, 0, 0, 7);
    send_command(CMD_TOPIC_REMOVE, 0, 0, 0, 7);
    send_command(CMD_TOPIC_ADD, 0, 0, 0, 7);
    send_command(CMD_TOPIC_ADD, 0, 0, 0, 0);
    send_command(CMD_SERVICE, 0, 0, 0, 0);
  endtask

  // Zero reload, re-adds on active slots, count wrap, and a fired alarm that keeps running.
  task automatic test_timers_and_alarms();
    send_command(CMD_TIMER_ADD, 0, 2, 0, 0);
    send_command(CMD_TIMER_ADD, 0, 5, 5, 7);
    send_command(CMD_TIMER_ADD, 7, '1, '1, 7);
    send_command(CMD_ALARM_COUNT, 7, 1, 0, 0);
    send_command(CMD_ALARM_ADD, 7, 0, 0, 0);
    send_command(CMD_ALARM_ADD, 7, 0, 0, 0);
    send_command(CMD_ALARM_ADD, 0, 0, 0, 0);
    send_command(CMD_TICK, 0, 0, 0, 0);
    send_command(CMD_TICK, 0, 0, 0, 0);
    send_command(CMD_SERVICE, 0, 0, 0, 0);
    send_command(CMD_TICK, 0, 0, 0, 0);
    send_command(CMD_ALARM_REMOVE, 0, 0, 0, 0);
    send_command(CMD_TIMER_REMOVE, 0, 0, 0, 0);
    send_command(CMD_TIMER_REMOVE, 7, 0, 0, 0);
    send_command(CMD_SERVICE, 0, 0, 0, 0);
  endtask

  // Every topic registered and pending plus, with scheduling on, a fired alarm: the longest service burst.
  task automatic test_full_dispatch();
    logic [SLOT_W-1:0] alarm_slot;
    alarm_slot = SLOT_W'($urandom);
    for (int i = 0; i < TOPIC_SLOTS; i++) begin
      send_command(CMD_TOPIC_ADD, SLOT_W'($urandom), $urandom, $urandom, TOPIC_AW'(i));
      send_command(CMD_PUBLISH, SLOT_W'($urandom), $urandom, $urandom, TOPIC_AW'(i));
    end
    send_command(CMD_ALARM_COUNT, alarm_slot, 1, $urandom, TOPIC_AW'($urandom));
    send_command(CMD_ALARM_ADD, alarm_slot, $urandom, $urandom, TOPIC_AW'($urandom));
    send_command(CMD_TICK, SLOT_W'($urandom), $urandom, $urandom, TOPIC_AW'($urandom));
    send_command(CMD_SERVICE, SLOT_W'($urandom), $urandom, $urandom, TOPIC_AW'($urandom));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic sched, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_schedule(sched);
    test_full_dispatch();
    repeat (count) send_random_command();
  endtask

  always @(posedge clk) begin
    evt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    bank_event_t want;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      result_count++;
      if (pending_events.size() == 0) begin
        report_error($sformatf("unexpected event: kind %0d id %0d tick %0d last %0b",
                               evt_ch.event_kind, evt_ch.event_id, evt_ch.tick_now,
                               evt_ch.last));
      end else begin
        want = pending_events.pop_front();
        if (evt_ch.event_kind !== want.kind)
          report_error($sformatf("event_kind: got %0d, expected %0d",
                                 evt_ch.event_kind, want.kind));
        if (evt_ch.event_id !== want.id)
          report_error($sformatf("event_id: got %0d, expected %0d",
                                 evt_ch.event_id, want.id));
        if (evt_ch.tick_now !== want.tick)
          report_error($sformatf("tick_now: got %0h, expected %0h",
                                 evt_ch.tick_now, want.tick));
        if (evt_ch.last !== want.last)
          report_error($sformatf("last: got %0b, expected %0b", evt_ch.last, want.last));
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_write_data      = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = '0;
    req_ch.slot         = '0;
    req_ch.count_value  = '0;
    req_ch.reload_value = '0;
    req_ch.topic_id     = '0;
    evt_ch.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    error_count         = 0;
    command_count       = 0;
    result_count        = 0;
    topic_event_count   = 0;
    alarm_event_count   = 0;
    schedule_writes     = 0;
    tick_count          = '0;
    sched_on            = 1'b0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      tmr_active[i] = 1'b0;
      tmr_count[i]  = '0;
      tmr_reload[i] = '0;
      tmr_target[i] = '0;
    end
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      alm_active[i] = 1'b0;
      alm_count[i]  = '0;
      alm_fired[i]  = 1'b0;
    end
    for (int i = 0; i < TOPIC_SLOTS; i++) begin
      topic_reg[i]  = 1'b0;
      topic_pend[i] = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_schedule(1'b0);
    test_idle_bank();
    set_schedule(1'b1);
    test_timers_and_alarms();

    test_random_traffic(0, 0, 1'b1, 35);
    test_random_traffic(83, 0, 1'b1, 35);
    test_random_traffic(0, 83, 1'b0, 35);
    test_random_traffic(32, 32, 1'b1, 35);

    drain_events();
    repeat (40) @(posedge clk);

    $display("Sent %0d commands over %0d scheduling settings and four pacing mixes.",
             command_count, schedule_writes);
    $display("Checked %0d events: %0d topic events, %0d fired alarms.",
             result_count, topic_event_count, alarm_event_count);
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/stab_pkg.sv
sv/stab_req_if.sv
sv/stab_evt_if.sv
sv/stab_ctrl.sv
sv/stab_datapath.sv
sv/soft_timer_alarm_event_bank_top.sv
sv/stab_checker.sv
tb/sv/tb.sv
